// ===== rtl/pd_pkg.sv =====
package pd_pkg;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int OBUF_DEPTH = 4;
    localparam int OBUF_AW    = $clog2(OBUF_DEPTH);
    localparam int OBUF_CW    = $clog2(OBUF_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_HIGH = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_beat;

    // up to two output beats produced by one input beat
    typedef struct packed {
        logic [1:0] cnt;
        t_beat      b0;
        t_beat      b1;
    } t_dec;

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        if (c inside {[8'h41:8'h5A]}) begin
            v = c - 8'd55;
        end else if (c inside {[8'h61:8'h7A]}) begin
            v = c - 8'd87;
        end else if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'h30;
        end else begin
            v = c;
        end
        return v;
    endfunction

endpackage

// ===== rtl/pd_decode.sv =====
module pd_decode
    import pd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_beat i_beat,
    output t_dec  o_dec
);

    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_held;
    logic [7:0] n_held;
    logic [7:0] lo_val;
    logic [7:0] hi_val;

    assign hi_val = digit_value(r_held);
    assign lo_val = digit_value(i_beat.data);

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        o_dec   = '0;
        if (i_valid) begin
            case (r_phase)
                PH_PCT: begin
                    if (i_beat.last) begin
                        // string ends after one digit: emit it raw behind '%'
                        o_dec.cnt = 2'd2;
                        o_dec.b0  = '{data: CH_PCT, last: 1'b0};
                        o_dec.b1  = '{data: i_beat.data, last: 1'b1};
                        n_phase   = PH_IDLE;
                    end else begin
                        n_held  = i_beat.data;
                        n_phase = PH_HIGH;
                    end
                end
                PH_HIGH: begin
                    o_dec.cnt = 2'd1;
                    o_dec.b0  = '{data: {hi_val[3:0], 4'h0} + lo_val, last: i_beat.last};
                    n_phase   = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                    if (i_beat.data == CH_PLUS) begin
                        o_dec.cnt = 2'd1;
                        o_dec.b0  = '{data: CH_SPACE, last: i_beat.last};
                    end else if (i_beat.data == CH_PCT) begin
                        if (i_beat.last) begin
                            o_dec.cnt = 2'd1;
                            o_dec.b0  = '{data: CH_PCT, last: 1'b1};
                        end else begin
                            n_phase = PH_PCT;
                        end
                    end else begin
                        o_dec.cnt = 2'd1;
                        o_dec.b0  = i_beat;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= '0;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    a_last_ends_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_beat.last) |=> (r_phase == PH_IDLE))
        else $error("escape still pending after last beat");

    a_phase_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_valid |=> $stable(r_phase))
        else $error("phase moved without an input beat");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dec.cnt != 2'd3)
        else $error("more than two outputs for one beat");

endmodule

// ===== rtl/pd_obuf.sv =====
module pd_obuf
    import pd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_dec  i_push,
    input  logic  i_pop,
    output logic  o_space,
    output logic  o_valid,
    output t_beat o_beat
);

    t_beat              r_mem [OBUF_DEPTH];
    logic [OBUF_AW-1:0] r_head;
    logic [OBUF_AW-1:0] r_tail;
    logic [OBUF_CW-1:0] r_count;
    logic [OBUF_AW-1:0] tail_nxt;
    logic               pop_ok;

    // room for the worst case of two beats
    assign o_space  = (r_count <= OBUF_CW'(OBUF_DEPTH - 2));
    assign o_valid  = (r_count != '0);
    assign o_beat   = r_mem[r_head];
    assign pop_ok   = i_pop && o_valid;
    assign tail_nxt = r_tail + OBUF_AW'(1);

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_tail] <= i_push.b0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[tail_nxt] <= i_push.b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + OBUF_AW'(i_push.cnt);
            r_head  <= r_head + OBUF_AW'(pop_ok);
            r_count <= r_count + OBUF_CW'(i_push.cnt) - OBUF_CW'(pop_ok);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OBUF_CW'(OBUF_DEPTH))
        else $error("output buffer count out of range");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> o_space)
        else $error("push into a buffer without room");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tail - r_head) == OBUF_AW'(r_count))
        else $error("pointers disagree with count");

endmodule

// ===== rtl/percent_decoder.sv =====
// URL percent decoder, one encoded byte per beat.
// An input beat is registered, then queued, before the first output beat it causes.
// Throughput: one input beat per cycle while the 4-entry output queue has room
// for two beats; it absorbs the two-beat case (truncated escape) and output stalls.
// Reset (synchronous, active low) clears the escape state and empties all stages.
module percent_decoder
    import pd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast
);

    logic  r_in_valid;
    t_beat r_in;
    logic  consume;
    logic  space;
    t_dec  dec;
    t_beat out_beat;

    assign consume       = r_in_valid && space;
    assign s_axis_tready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= '{data: s_axis_tdata, last: s_axis_tlast};
        end
    end

    pd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (consume),
        .i_beat  (r_in),
        .o_dec   (dec)
    );

    pd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (dec),
        .i_pop   (m_axis_tready),
        .o_space (space),
        .o_valid (m_axis_tvalid),
        .o_beat  (out_beat)
    );

    assign m_axis_tdata = out_beat.data;
    assign m_axis_tlast = out_beat.last;

    a_stalled_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !consume) |=> (r_in_valid && $stable(r_in)))
        else $error("stalled input beat lost");

    a_no_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !consume |-> (dec.cnt == 2'd0))
        else $error("output produced without an input beat");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input blocked while the stage is empty");

endmodule
